[hw/rtl/kiv_pkg.sv]
// kiv_pkg: constants and status codes for the kernel image verifier
// used by kernel_image_verifier, its port checker and its testbench; no dependencies
`default_nettype none

package kiv_pkg;

	localparam int WORD_W   = 16;
	localparam int SECT_W   = 8;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 1;

	// words per sector is 2**SECTOR_LOG2 (512-byte sectors of 16-bit words)
	localparam int SECTOR_LOG2 = 8;

	localparam logic [7:0]        STUB_BYTE        = 8'hEB;
	localparam logic [SECT_W-1:0] MIN_SECTORS_RST  = 8'd8;
	localparam logic [SECT_W-1:0] MAX_SECTORS_RST  = 8'd255;
	localparam logic [SECT_W-1:0] SECTORS_SAT      = 8'd255;

	// header word positions
	localparam logic [WORD_W-1:0] HDR_STUB_IDX = 16'd0;
	localparam logic [WORD_W-1:0] HDR_SUM_IDX  = 16'd2;
	localparam logic [WORD_W-1:0] HDR_SECT_IDX = 16'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SECTORS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SECTORS = 1'd1;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK           = 3'd0;
	localparam status_t ST_BAD_SIZE     = 3'd1;
	localparam status_t ST_NO_STUB      = 3'd2;
	localparam status_t ST_SECT_MISMATCH = 3'd3;
	localparam status_t ST_SUM_MISMATCH = 3'd4;

endpackage

`default_nettype wire

[hw/rtl/kernel_image_verifier.sv]
// kernel_image_verifier: streaming size, stub, header and checksum check of an image
// depends on kiv_pkg
//
//  channel | signals                                  | direction | handshake
//  --------+------------------------------------------+-----------+----------------------
//  in      | data_word[15:0], last_word               | to block  | in_valid / in_ready
//  out     | status[2:0], sector_count[7:0],          | from block| out_valid / out_ready
//          | computed_sum[15:0]                       |           |
//  cfg     | cfg_index[0], cfg_data[7:0]              | to block  | cfg_valid / cfg_ready
//
// one item per cycle while no last item is held back: an item is registered at accept, folded
// into the image state in the next cycle; the result register loads when the last item advances
// the output register lets the next image stream in while a result waits
// only a last item stalls in the input register, and only while a result is still held
// arst_n clears all image state and sets min_sectors to 8, max_sectors to 255
`default_nettype none

module kernel_image_verifier
	import kiv_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [WORD_W-1:0]    data_word,
	input  wire logic                 last_word,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [STATUS_W-1:0]       status,
	output logic [SECT_W-1:0]         sector_count,
	output logic [WORD_W-1:0]         computed_sum,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SECT_W-1:0]    cfg_data
);

	// input register
	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              last_s1;

	// configuration
	logic [SECT_W-1:0] min_sectors_q;
	logic [SECT_W-1:0] max_sectors_q;

	// image state
	logic [WORD_W-1:0] word_count_q;
	logic              count_ovf_q;
	logic [WORD_W-1:0] run_sum_q;
	logic              stub_ok_q;
	logic [WORD_W-1:0] exp_sum_q;
	logic [WORD_W-1:0] exp_sect_q;

	// output register
	logic                out_valid_q;
	status_t             status_q;
	logic [SECT_W-1:0]   sect_q;
	logic [WORD_W-1:0]   sum_q;

	logic advance;
	logic out_free;

	logic [WORD_W-1:0] term;
	logic              stub_ok_d;
	logic [WORD_W-1:0] exp_sum_d;
	logic [WORD_W-1:0] exp_sect_d;
	logic [WORD_W-1:0] run_sum_d;
	logic              wc_full;
	logic              count_ovf_d;
	logic [WORD_W-1:0] word_count_d;
	logic [SECT_W-1:0] sectors;
	logic              size_bad;
	status_t           status_d;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_comb begin
		term       = word_s1;
		stub_ok_d  = stub_ok_q;
		exp_sum_d  = exp_sum_q;
		exp_sect_d = exp_sect_q;
		// header fields only while the count is exact
		if (!count_ovf_q) begin
			if (word_count_q == HDR_STUB_IDX) begin
				stub_ok_d = (word_s1[7:0] == STUB_BYTE);
			end
			if (word_count_q == HDR_SUM_IDX) begin
				exp_sum_d = word_s1;
				term      = '0;
			end
			if (word_count_q == HDR_SECT_IDX) begin
				exp_sect_d = word_s1;
			end
		end

		run_sum_d    = {run_sum_q[WORD_W-2:0], run_sum_q[WORD_W-1]} + term;
		wc_full      = &word_count_q;
		count_ovf_d  = count_ovf_q || wc_full;
		word_count_d = wc_full ? word_count_q : word_count_q + 1'b1;

		sectors  = count_ovf_d ? SECTORS_SAT : word_count_d[WORD_W-1 -: SECT_W];
		size_bad = count_ovf_d || (word_count_d[SECTOR_LOG2-1:0] != '0) ||
			(sectors < min_sectors_q) || (sectors > max_sectors_q);

		if (size_bad) begin
			status_d = ST_BAD_SIZE;
		end else if (!stub_ok_d) begin
			status_d = ST_NO_STUB;
		end else if (exp_sect_d != {{(WORD_W-SECT_W){1'b0}}, sectors}) begin
			status_d = ST_SECT_MISMATCH;
		end else if (run_sum_d != exp_sum_d) begin
			status_d = ST_SUM_MISMATCH;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= data_word;
			last_s1 <= last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sectors_q <= MIN_SECTORS_RST;
			max_sectors_q <= MAX_SECTORS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_SECTORS: min_sectors_q <= cfg_data;
				CFG_MAX_SECTORS: max_sectors_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
			count_ovf_q  <= 1'b0;
			run_sum_q    <= '0;
			stub_ok_q    <= 1'b0;
			exp_sum_q    <= '0;
			exp_sect_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				// image done, start over for the next one
				word_count_q <= '0;
				count_ovf_q  <= 1'b0;
				run_sum_q    <= '0;
				stub_ok_q    <= 1'b0;
				exp_sum_q    <= '0;
				exp_sect_q   <= '0;
			end else begin
				word_count_q <= word_count_d;
				count_ovf_q  <= count_ovf_d;
				run_sum_q    <= run_sum_d;
				stub_ok_q    <= stub_ok_d;
				exp_sum_q    <= exp_sum_d;
				exp_sect_q   <= exp_sect_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= status_d;
			sect_q   <= sectors;
			sum_q    <= run_sum_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign sector_count = sect_q;
	assign computed_sum = sum_q;

endmodule

`default_nettype wire

[hw/rtl/kiv_port_check.sv]
// kiv_port_check: port-level checks on kernel_image_verifier, bound into each of its instances
// depends on kiv_pkg
`default_nettype none

module kiv_port_check
	import kiv_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 last_word,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [STATUS_W-1:0]  status,
	input wire logic [SECT_W-1:0]    sector_count,
	input wire logic [WORD_W-1:0]    computed_sum
);

	// a held result must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
			$stable(sector_count) && $stable(computed_sum))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_BAD_SIZE || status == ST_NO_STUB ||
			status == ST_SECT_MISMATCH || status == ST_SUM_MISMATCH))
		else $error("status code out of range");

	// a passing image holds at least one whole sector
	a_ok_has_sectors: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> sector_count != '0)
		else $error("ok status with zero sectors");

	// a fresh result follows a last item accepted earlier, by way of the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && last_word, 2))
		else $error("result without a last item");

endmodule

bind kernel_image_verifier kiv_port_check u_kiv_port_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.last_word    (last_word),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.sector_count (sector_count),
	.computed_sum (computed_sum)
);

`default_nettype wire

[dv/kernel_image_verifier_tb.sv]
// testbench for kernel_image_verifier: image streams with header, size and checksum cases
// keeps its own prediction of every verdict and checks each result against it
// depends on kiv_pkg and the kernel_image_verifier rtl
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kiv_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		status_t               st;
		logic [SECT_W-1:0]     sectors;
		logic [WORD_W-1:0]     sum;
	} verdict_t;

	typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES, FILL_NOISE} fill_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [WORD_W-1:0]    data_word = '0;
	logic                 last_word = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [SECT_W-1:0]    sector_count;
	logic [WORD_W-1:0]    computed_sum;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SECT_W-1:0]    cfg_data = '0;

	// predicted image state and register copies
	logic [WORD_W-1:0] img_words = '0;
	logic              img_ovf = 1'b0;
	logic [WORD_W-1:0] img_sum = '0;
	logic              img_stub = 1'b0;
	logic [WORD_W-1:0] hdr_sum = '0;
	logic [WORD_W-1:0] hdr_sect = '0;
	logic [SECT_W-1:0] bound_min = MIN_SECTORS_RST;
	logic [SECT_W-1:0] bound_max = MAX_SECTORS_RST;

	verdict_t          verdict_q[$];
	verdict_t          want;
	logic [WORD_W-1:0] img_buf[$];

	int fail_cnt = 0;
	int words_sent = 0;
	int verdicts_done = 0;
	int burst_left = 0;
	bit tx_gaps = 1'b1;

	// receiver pattern state
	bit hold_tog = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int rx_style = 0;
	int style_left = 0;
	int run_left = 0;
	int quiet = 0;

	kernel_image_verifier i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_word    (data_word),
		.last_word    (last_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.sector_count (sector_count),
		.computed_sum (computed_sum),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// fold one accepted word into the predicted image, queue a verdict on the last one
	task automatic fold_word(input logic [WORD_W-1:0] w, input logic l);
		logic [WORD_W-1:0] term;
		logic [SECT_W-1:0] sect;
		logic              size_bad;
		verdict_t          v;
		term = w;
		if (!img_ovf) begin
			if (img_words == HDR_STUB_IDX) begin
				img_stub = (w[7:0] == STUB_BYTE);
			end else if (img_words == HDR_SUM_IDX) begin
				hdr_sum = w;
				term = '0;
			end else if (img_words == HDR_SECT_IDX) begin
				hdr_sect = w;
			end
		end
		img_sum = {img_sum[WORD_W-2:0], img_sum[WORD_W-1]} + term;
		if (img_words == '1)
			img_ovf = 1'b1;
		else
			img_words = img_words + 1'b1;
		if (l) begin
			sect = img_ovf ? SECTORS_SAT : img_words[WORD_W-1:SECTOR_LOG2];
			size_bad = img_ovf || (img_words[SECTOR_LOG2-1:0] != '0) ||
				(sect < bound_min) || (sect > bound_max);
			if (size_bad)
				v.st = ST_BAD_SIZE;
			else if (!img_stub)
				v.st = ST_NO_STUB;
			else if (hdr_sect != {{(WORD_W-SECT_W){1'b0}}, sect})
				v.st = ST_SECT_MISMATCH;
			else if (img_sum != hdr_sum)
				v.st = ST_SUM_MISMATCH;
			else
				v.st = ST_OK;
			v.sectors = sect;
			v.sum = img_sum;
			verdict_q.push_back(v);
			img_words = '0;
			img_ovf = 1'b0;
			img_sum = '0;
			img_stub = 1'b0;
			hdr_sum = '0;
			hdr_sect = '0;
		end
	endtask

	// called at a rising edge; returns at the edge that accepted the item or after a gap
	task automatic send_word(input logic [WORD_W-1:0] w, input logic l);
		logic hit;
		in_valid <= 1'b1;
		data_word <= w;
		last_word <= l;
		do begin
			@(negedge clk);
			hit = in_ready;
			@(posedge clk);
		end while (!hit);
		fold_word(w, l);
		words_sent++;
		if (tx_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end else if (burst_left != 0) begin
			burst_left--;
		end
	endtask

	// build an image with a valid header unless a fault or noise fill is asked for, then stream it
	task automatic send_image(input int nwords, input fill_e fill,
			input bit bad_stub, input bit bad_sect, input bit bad_sum);
		logic [WORD_W-1:0] acc;
		logic [7:0]        lowb;
		img_buf.delete();
		for (int i = 0; i < nwords; i++) begin
			case (fill)
				FILL_ZERO: img_buf.push_back('0);
				FILL_ONES: img_buf.push_back('1);
				default:   img_buf.push_back(WORD_W'($urandom));
			endcase
		end
		if (fill != FILL_NOISE) begin
			lowb = STUB_BYTE;
			if (bad_stub) begin
				lowb = 8'($urandom_range(0, 254));
				if (lowb >= STUB_BYTE)
					lowb = lowb + 1'b1;
			end
			img_buf[HDR_STUB_IDX] = {img_buf[HDR_STUB_IDX][WORD_W-1:8], lowb};
			if (nwords > HDR_SECT_IDX) begin
				img_buf[HDR_SECT_IDX] = WORD_W'(nwords >> SECTOR_LOG2);
				if (bad_sect)
					img_buf[HDR_SECT_IDX] ^= WORD_W'(1) << $urandom_range(0, WORD_W - 1);
			end
			if (nwords > HDR_SUM_IDX) begin
				acc = '0;
				for (int i = 0; i < nwords; i++)
					acc = {acc[WORD_W-2:0], acc[WORD_W-1]} +
						((i == HDR_SUM_IDX) ? WORD_W'(0) : img_buf[i]);
				if (bad_sum)
					acc ^= WORD_W'(1) << $urandom_range(0, WORD_W - 1);
				img_buf[HDR_SUM_IDX] = acc;
			end
		end
		for (int i = 0; i < img_buf.size(); i++)
			send_word(img_buf[i], i == img_buf.size() - 1);
	endtask

	// wait until every verdict is out and the pipeline has settled
	task automatic drain();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SECT_W-1:0] val);
		logic hit;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			hit = cfg_ready;
			@(posedge clk);
		end while (!hit);
		if (idx == CFG_MIN_SECTORS)
			bound_min = val;
		else
			bound_max = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_bounds(input int lo, input int hi);
		drain();
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_MIN_SECTORS, SECT_W'(lo));
			write_reg(CFG_MAX_SECTORS, SECT_W'(hi));
		end else begin
			write_reg(CFG_MAX_SECTORS, SECT_W'(hi));
			write_reg(CFG_MIN_SECTORS, SECT_W'(lo));
		end
	endtask

	task automatic test_reset_bounds();
		send_image(8 * 256, FILL_RAND, 0, 0, 0);
		send_image(7 * 256, FILL_RAND, 0, 0, 0);
	endtask

	task automatic test_header_checks();
		set_bounds(1, 4);
		send_image(256, FILL_RAND, 0, 0, 0);
		send_image(256, FILL_RAND, 1, 0, 0);
		send_image(512, FILL_RAND, 0, 1, 0);
		send_image(256, FILL_RAND, 0, 0, 1);
		// first failing check wins
		send_image(256, FILL_RAND, 1, 0, 1);
		send_image(256, FILL_RAND, 0, 1, 1);
		send_image(257, FILL_RAND, 1, 1, 1);
		send_image(256, FILL_ONES, 0, 0, 0);
		send_image(4 * 256, FILL_ZERO, 0, 0, 0);
	endtask

	task automatic test_short_images();
		set_bounds(1, 4);
		// header words that never arrived read as zero
		for (int n = 1; n <= 4; n++) begin
			send_image(n, FILL_RAND, 0, 0, 0);
			send_image(n, FILL_NOISE, 0, 0, 0);
		end
		send_image(1, FILL_ONES, 0, 0, 0);
		send_image(1, FILL_ZERO, 0, 0, 0);
	endtask

	task automatic test_bound_extremes();
		set_bounds(1, 1);
		send_image(256, FILL_RAND, 0, 0, 0);
		send_image(512, FILL_RAND, 0, 0, 0);
		// min above max rejects everything
		set_bounds(3, 2);
		send_image(512, FILL_RAND, 0, 0, 0);
		send_image(768, FILL_RAND, 0, 0, 0);
		set_bounds(255, 255);
		send_image(255 * 256, FILL_RAND, 0, 0, 0);
	endtask

	task automatic test_count_overflow();
		set_bounds(1, 255);
		tx_gaps = 1'b0;
		send_image(65535, FILL_RAND, 0, 0, 0);
		send_image(65536, FILL_RAND, 0, 0, 0);
		send_image(65537, FILL_NOISE, 0, 0, 0);
		tx_gaps = 1'b1;
		send_image(256, FILL_RAND, 0, 0, 0);
	endtask

	task automatic test_backpressure();
		set_bounds(1, 4);
		tx_gaps = 1'b0;
		hold_tog <= ~hold_tog;
		for (int i = 0; i < 8; i++)
			send_image($urandom_range(1, 3), FILL_RAND, 0, 0, 0);
		tx_gaps = 1'b1;
	endtask

	task automatic test_random_images();
		int words_goal;
		int nimg;
		int lo;
		int hi;
		int nsect;
		int nwords;
		int top;
		words_goal = words_sent + 1600;
		nimg = 0;
		lo = 1;
		hi = 4;
		while (words_sent < words_goal || nimg < 48) begin
			if (nimg % 8 == 0) begin
				case ($urandom_range(0, 9))
					0: begin
						lo = 1;
						hi = 255;
					end
					1: begin
						lo = $urandom_range(2, 4);
						hi = lo - 1;
					end
					2: begin
						lo = 255;
						hi = 255;
					end
					default: begin
						lo = $urandom_range(1, 3);
						hi = $urandom_range(lo, 4);
					end
				endcase
				set_bounds(lo, hi);
			end
			if ($urandom_range(0, 99) < 65) begin
				top = (hi < 3) ? hi : 3;
				if (lo <= top && $urandom_range(0, 4) != 0)
					nsect = $urandom_range(lo, top);
				else
					nsect = $urandom_range(1, 4);
				nwords = nsect * 256;
				if ($urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 1))
						nwords += $urandom_range(1, 255);
					else
						nwords -= $urandom_range(1, 3);
				end
				send_image(nwords, FILL_RAND, $urandom_range(0, 7) == 0,
					$urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0);
			end else begin
				send_image($urandom_range(1, 40), FILL_NOISE, 0, 0, 0);
			end
			nimg++;
		end
	endtask

	// receiver: changing stall styles, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				rx_style <= $urandom_range(0, 3);
				style_left <= $urandom_range(16, 128);
			end else begin
				style_left <= style_left - 1;
			end
			case (rx_style)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: begin
					if (run_left == 0) begin
						out_ready <= ~out_ready;
						run_left <= $urandom_range(1, 20);
					end else begin
						run_left <= run_left - 1;
					end
				end
			endcase
		end
	end

	// result check; signals are stable at the falling edge before the accepting edge
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$error("result with no image pending: status %0d sector_count %0d computed_sum %h",
					status, sector_count, computed_sum);
				fail_cnt++;
			end else begin
				want = verdict_q.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					fail_cnt++;
				end
				if (sector_count !== want.sectors) begin
					$error("sector_count: expected %0d, got %0d", want.sectors, sector_count);
					fail_cnt++;
				end
				if (computed_sum !== want.sum) begin
					$error("computed_sum: expected %h, got %h", want.sum, computed_sum);
					fail_cnt++;
				end
			end
			verdicts_done++;
		end
	end

	// watchdog: a stretch with no handshake at all that reaches QUIET_LIMIT ends the run
	initial begin
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$error("no item moved for %0d cycles", QUIET_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_bounds();
		test_header_checks();
		test_short_images();
		test_bound_extremes();
		test_count_overflow();
		test_backpressure();
		test_random_images();
		drain();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
